// ===== design/bla_pkg.sv =====
// shared types, codes and widths for the bounded list append/remove unit
package bla_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int MODE_W       = 2;
    localparam int POS_W        = 4;
    localparam int STATUS_W     = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND      = 2'd0,
        MODE_REMOVE_LAST = 2'd1,
        MODE_REMOVE_HEAD = 2'd2,
        MODE_REMOVE_AT   = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // per-cell control for one command
    typedef struct packed {
        logic load;   // take the appended word
        logic shift;  // take the right neighbor's word
        logic sel;    // drive own word onto the read bus
    } cell_ctrl_t;

endpackage

// ===== design/bla_cell.sv =====
// one storage cell of the list chain: holds one element, shifts from its right neighbor
module bla_cell (
    input  logic                        clk,
    input  bla_pkg::cell_ctrl_t         ctrl,
    input  logic [bla_pkg::DATA_W-1:0]  value_in,
    input  logic [bla_pkg::DATA_W-1:0]  neighbor_in,
    output logic [bla_pkg::DATA_W-1:0]  data_out,
    output logic [bla_pkg::DATA_W-1:0]  tap_out
);
    import bla_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = value_in;
        end
        else if (ctrl.shift)
        begin
            data_next = neighbor_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;
    assign tap_out  = ctrl.sel ? data_reg : '0;

endmodule

// ===== design/bounded_list_append_remove_unit.sv =====
// top level of the bounded list unit: command register, cell chain and result register
//
// usage
//   commands arrive on in_valid/in_ready with mode, value and position; one word
//   per command. results leave on out_valid/out_ready with removed_value, status
//   and count, exactly one result word per command, in command order.
//   a command is latched at acceptance and executed once the result register is
//   free; the executed result is registered and offered on out_valid.
//   the unit takes no new command until the latched one has executed: the
//   command is latched, then every cell of the chain shifts or loads in parallel
//   and the result register is written.
//   if the receiver stalls, the executed command waits in the result register;
//   the next command is still accepted and held until that result is taken.
//   reset (rst_n low, asynchronous) empties the list and drops any pending
//   command and result; the cell contents are not cleared, only the count is.
//   appending to a full list, removing from an empty list, or removing at a
//   position not below the count leaves the list untouched and reports an
//   error status with removed_value of zero.
module bounded_list_append_remove_unit #(
    parameter int CAPACITY = bla_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bla_pkg::MODE_W-1:0]          mode,
    input  logic signed [bla_pkg::DATA_W-1:0]   value,
    input  logic [bla_pkg::POS_W-1:0]           position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [bla_pkg::DATA_W-1:0]   removed_value,
    output logic [bla_pkg::STATUS_W-1:0]        status,
    output logic [CNT_W-1:0]                    count
);
    import bla_pkg::*;

    // common width for comparing positions, cell indexes and counts
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // command register
    logic                busy_reg;
    logic                busy_next;
    mode_t               cmd_mode_reg;
    logic [DATA_W-1:0]   cmd_value_reg;
    logic [POS_W-1:0]    cmd_pos_reg;

    // list occupancy
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    // result register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [DATA_W-1:0]   removed_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CNT_W-1:0]    count_out_reg;

    // execute-cycle decode
    logic                in_fire;
    logic                exec;
    status_t             exec_status;
    logic                do_append;
    logic                do_remove;
    logic [CMP_W-1:0]    rm_idx;
    logic [CMP_W-1:0]    cnt_ext;
    logic [DATA_W-1:0]   removed_bus;

    cell_ctrl_t          cell_ctrl [CAPACITY];
    logic [DATA_W-1:0]   cell_data [CAPACITY];
    logic [DATA_W-1:0]   cell_tap  [CAPACITY];

    assign in_ready = !busy_reg;
    assign in_fire  = in_valid && in_ready;
    // the result register must be free (or being emptied) to execute
    assign exec     = busy_reg && (!out_valid_reg || out_ready);
    assign cnt_ext  = CMP_W'(count_reg);

    // status and target index of the latched command
    always_comb
    begin
        exec_status = ST_OK;
        rm_idx      = '0;
        case (cmd_mode_reg)
            MODE_APPEND:
            begin
                if (count_reg == CNT_W'(CAPACITY))
                begin
                    exec_status = ST_FULL;
                end
            end
            MODE_REMOVE_LAST:
            begin
                rm_idx = cnt_ext - CMP_W'(1);
                if (count_reg == '0)
                begin
                    exec_status = ST_EMPTY;
                end
            end
            MODE_REMOVE_HEAD:
            begin
                rm_idx = '0;
                if (count_reg == '0)
                begin
                    exec_status = ST_EMPTY;
                end
            end
            MODE_REMOVE_AT:
            begin
                rm_idx = CMP_W'(cmd_pos_reg);
                // empty is reported before the position check
                if (count_reg == '0)
                begin
                    exec_status = ST_EMPTY;
                end
                else if (CMP_W'(cmd_pos_reg) >= cnt_ext)
                begin
                    exec_status = ST_RANGE;
                end
            end
            default:
            begin
                exec_status = ST_OK;
            end
        endcase
    end

    assign do_append = exec && (exec_status == ST_OK) && (cmd_mode_reg == MODE_APPEND);
    assign do_remove = exec && (exec_status == ST_OK) && (cmd_mode_reg != MODE_APPEND);

    // per-cell control: cells at and above the removed slot shift down, the
    // slot at the tail takes an appended word, the removed slot drives the bus
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_ctrl[i].load  = do_append && (CMP_W'(i) == cnt_ext);
            cell_ctrl[i].shift = do_remove && (CMP_W'(i) >= rm_idx);
            cell_ctrl[i].sel   = do_remove && (CMP_W'(i) == rm_idx);
        end
    end

    // the cell chain
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_W-1:0] neighbor;
        if (g == CAPACITY - 1)
        begin : g_last
            assign neighbor = '0;
        end
        else
        begin : g_mid
            assign neighbor = cell_data[g + 1];
        end

        bla_cell u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl[g]),
            .value_in    (cmd_value_reg),
            .neighbor_in (neighbor),
            .data_out    (cell_data[g]),
            .tap_out     (cell_tap[g])
        );
    end

    // only the selected cell drives a nonzero tap
    always_comb
    begin
        removed_bus = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            removed_bus = removed_bus | cell_tap[i];
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (exec)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
        end
        if (in_fire)
        begin
            busy_next = 1'b1;
        end
        if (do_append)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_mode_reg  <= mode_t'(mode);
            cmd_value_reg <= value;
            cmd_pos_reg   <= position;
        end
        if (exec)
        begin
            removed_reg   <= removed_bus;
            status_reg    <= exec_status;
            count_out_reg <= count_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign removed_value = removed_reg;
    assign status        = status_reg;
    assign count         = count_out_reg;

`ifndef ASSERT_OFF
    // occupancy never exceeds the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    // a successful append grows the list by one
    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_append |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("append did not grow the list");

    // a successful removal shrinks the list by one
    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        do_remove |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("removal did not shrink the list");

    // an error result never carries a removed element
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |-> removed_reg == '0)
        else $error("error result with nonzero removed value");

    // executing always fills the result register
    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> out_valid_reg && !busy_reg)
        else $error("executed command produced no result");
`endif

endmodule

// ===== tb/list_check_pkg.sv =====
// list predictor and pending result store for the bounded list unit testbench
package list_check_pkg;

    import bla_pkg::*;

    localparam int LIST_CAP   = CAPACITY_DEF;
    localparam int CNT_W      = $clog2(LIST_CAP + 1);
    localparam int SHOW_LIMIT = 40;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed;
        status_t                  status;
        logic [CNT_W-1:0]         count;
    } list_result_t;

    class list_scoreboard;

        logic signed [DATA_W-1:0] cells [LIST_CAP];
        int                       held;
        list_result_t             pending_results [$];
        int                       results_seen;
        int                       errors;

        function new();
            held         = 0;
            results_seen = 0;
            errors       = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // work out the result of one accepted command and update the list copy
        function void apply_command(mode_t m, logic signed [DATA_W-1:0] v,
                                    logic [POS_W-1:0] p);
            list_result_t r;
            int           idx;
            bit           take;
            r.removed = '0;
            r.status  = ST_OK;
            take      = 1'b0;
            idx       = 0;
            if (m == MODE_APPEND)
            begin
                if (held >= LIST_CAP)
                    r.status = ST_FULL;
                else
                begin
                    cells[held] = v;
                    held++;
                end
            end
            else if (held == 0)
                r.status = ST_EMPTY;
            else if (m == MODE_REMOVE_LAST)
            begin
                idx  = held - 1;
                take = 1'b1;
            end
            else if (m == MODE_REMOVE_HEAD)
            begin
                idx  = 0;
                take = 1'b1;
            end
            else if (int'(p) >= held)
                r.status = ST_RANGE;
            else
            begin
                idx  = int'(p);
                take = 1'b1;
            end
            if (take)
            begin
                r.removed = cells[idx];
                for (int i = idx; i + 1 < held; i++)
                    cells[i] = cells[i + 1];
                held--;
            end
            r.count = CNT_W'(held);
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            if (errors < SHOW_LIMIT)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic signed [DATA_W-1:0] got_val, logic [STATUS_W-1:0] got_st,
                          logic [CNT_W-1:0] got_cnt);
            list_result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          results_seen));
                return;
            end
            want = pending_results.pop_front();
            if (got_val !== want.removed)
                report_mismatch($sformatf("result %0d removed_value %0d, wanted %0d",
                                          results_seen, got_val, want.removed));
            if (got_st !== want.status)
                report_mismatch($sformatf("result %0d status %0d, wanted %0d",
                                          results_seen, got_st, want.status));
            if (got_cnt !== want.count)
                report_mismatch($sformatf("result %0d count %0d, wanted %0d",
                                          results_seen, got_cnt, want.count));
        endtask

        task report_leftovers();
            if (pending_results.size() != 0)
                report_mismatch($sformatf("%0d results never arrived",
                                          pending_results.size()));
        endtask

    endclass

endpackage

// ===== tb/bounded_list_append_remove_unit_test.sv =====
// testbench top for the bounded list unit: directed and random commands, checked against a list copy
module bounded_list_append_remove_unit_test;

    import bla_pkg::*;
    import list_check_pkg::*;

    // longest stretch with no word moving on either side before giving up
    localparam int QUIET_LIMIT      = 2000;
    localparam int HOLD_OFF_CYCLES  = 150;
    localparam int RANDOM_PER_PHASE = 370;
    localparam int SETTLE_CYCLES    = 20;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [MODE_W-1:0]         mode;
    logic signed [DATA_W-1:0]  value;
    logic [POS_W-1:0]          position;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [DATA_W-1:0]  removed_value;
    logic [STATUS_W-1:0]       status;
    logic [CNT_W-1:0]          count;

    list_scoreboard sb;

    // idling knobs, percent of cycles
    int sender_idle_pct;
    int receiver_stall_pct;
    // receiver hold-off, counted down by the receiver process
    int hold_left;
    int quiet_cycles;
    // share of appends in the random part, moved around to fill and drain the list
    int append_bias;

    bounded_list_append_remove_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .value         (value),
        .position      (position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .removed_value (removed_value),
        .status        (status),
        .count         (count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver side: random stalls, or a long hold-off while hold_left runs down
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // every result word taken is checked against the oldest pending expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(removed_value, status, count);
    end

    // watchdog: ends a run in which words stop moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("[bounded_list_append_remove_unit] ERROR");
                    $finish;
                end
            end
        end
    end

    // corner values of a signed 32-bit word, random past the list
    function automatic logic signed [DATA_W-1:0] boundary_value(int k);
        case (k)
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0000_0000;
            3:       return 32'shffff_ffff;
            4:       return 32'sh0000_0001;
            5:       return 32'sh5555_5555;
            6:       return 32'shaaaa_aaaa;
            7:       return 32'sh8000_0001;
            8:       return 32'sh7fff_fffe;
            default: return $urandom;
        endcase
    endfunction

    // offer one command word and hold it until taken; leaves in_valid high
    task send_word(input mode_t m, input logic signed [DATA_W-1:0] v,
                   input logic [POS_W-1:0] p);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        value    <= v;
        position <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.apply_command(m, v, p);
    endtask

    // random command shaped by the current list fill
    task send_random_word();
        mode_t                    m;
        logic signed [DATA_W-1:0] v;
        logic [POS_W-1:0]         p;
        int                       held;
        held = sb.held;
        if ($urandom_range(99) < append_bias)
            m = MODE_APPEND;
        else
            m = mode_t'($urandom_range(3, 1));
        // value and position ride along on every command, used or not
        if ($urandom_range(3) == 0)
            v = boundary_value($urandom_range(8));
        else
            v = $urandom;
        // mostly valid positions, some past the count
        if (held > 0 && $urandom_range(99) < 85)
            p = POS_W'($urandom_range(held - 1));
        else
            p = POS_W'($urandom_range(15));
        send_word(m, v, p);
    endtask

    // stop offering and wait until every expected result has been taken
    task drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        int phase;
        int n;
        sb                 = new();
        clk                = 1'b0;
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        out_ready          = 1'b0;
        mode               = MODE_APPEND;
        value              = '0;
        position           = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_left          = 0;
        quiet_cycles       = 0;
        append_bias        = 50;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // removals from an empty list, remove-at included
        send_word(MODE_REMOVE_LAST, 32'sh1234_5678, 4'd0);
        send_word(MODE_REMOVE_HEAD, 32'sh7fff_ffff, 4'd15);
        send_word(MODE_REMOVE_AT, 32'sh8000_0000, 4'd15);
        // fill to capacity, corner values first and random words after them
        for (n = 0; n < LIST_CAP; n++)
            send_word(MODE_APPEND, boundary_value(n), 4'd15);
        // append to a full list
        send_word(MODE_APPEND, 32'sd99, 4'd0);
        // remove at the top position, then the same position once past the count
        send_word(MODE_REMOVE_AT, 32'sd0, 4'd15);
        send_word(MODE_REMOVE_AT, 32'sd0, 4'd15);
        // remove first returns the old head
        send_word(MODE_REMOVE_HEAD, 32'sd0, 4'd0);
        send_word(MODE_REMOVE_LAST, 32'sd0, 4'd0);
        send_word(MODE_REMOVE_AT, 32'sd0, 4'd0);
        send_word(MODE_REMOVE_AT, 32'sd0, 4'd7);

        // random part: no idling, sender idle, receiver stalling, both
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 72;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 72;
                end
                default:
                begin
                    sender_idle_pct    = 37;
                    receiver_stall_pct = 37;
                end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (n % 40 == 0)
                begin
                    case ($urandom_range(2))
                        0:       append_bias = 20;
                        1:       append_bias = 50;
                        default: append_bias = 85;
                    endcase
                end
                // long receiver hold-off while commands keep coming, so the unit backs up
                if (phase == 0 && n == 100)
                    hold_left = HOLD_OFF_CYCLES;
                // sender pause until the unit has handed back everything
                if (phase == 2 && n == 150)
                    drain();
                send_random_word();
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.report_leftovers();
        if (sb.errors == 0)
            $display("[bounded_list_append_remove_unit] OK");
        else
            $display("[bounded_list_append_remove_unit] ERROR");
        $finish;
    end

endmodule
